@@ rtl/h264_rtp_fu_a_packetizer_defines.svh @@
// Assertion macros used by the packetizer's output queue.
`ifndef H264_RTP_FU_A_PACKETIZER_DEFINES_SVH
`define H264_RTP_FU_A_PACKETIZER_DEFINES_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define H264FU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("h264fu assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define H264FU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("h264fu assertion failed");

`else

`define H264FU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define H264FU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/h264fu_pkg.sv @@
package h264fu_pkg;

    localparam int LENGTH_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int NAL_LENGTH_W = 16;
    localparam int MP_W         = 12;
    localparam int TS_STEP_W    = 17;
    localparam int SEQ_W        = 16;
    localparam int TS_W         = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 17;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMESTAMP_STEP = 2'd1;

    localparam logic [MP_W-1:0]      MAX_PAYLOAD_RESET = 12'd1400;
    localparam logic [TS_STEP_W-1:0] TS_STEP_RESET     = 17'd3600;

    localparam logic [7:0] NRI_MASK  = 8'h60;
    localparam logic [7:0] TYPE_MASK = 8'h1F;
    localparam logic [7:0] FU_A_TYPE = 8'd28;
    localparam logic [7:0] FU_START  = 8'h80;
    localparam logic [7:0] FU_END    = 8'h40;

    // one queued input byte: up to three output bytes
    typedef struct packed {
        logic [7:0]       fu_ind;
        logic [7:0]       fu_hdr;
        logic [7:0]       data;
        logic             has_hdr;
        logic             pkt_start;
        logic             pkt_end;
        logic [SEQ_W-1:0] seq;
        logic [TS_W-1:0]  ts;
    } entry_t;

    typedef enum logic [1:0] {
        BEAT_FIRST,
        BEAT_FUH,
        BEAT_DATA
    } beat_t;

endpackage

@@ rtl/h264fu_out_queue.sv @@
`include "h264_rtp_fu_a_packetizer_defines.svh"

module h264fu_out_queue #(
    parameter int DEPTH = h264fu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  h264fu_pkg::entry_t             in_entry,
    output logic                           in_ready,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_payload_byte,
    output logic                           m_packet_start,
    output logic                           m_packet_end,
    output logic [h264fu_pkg::SEQ_W-1:0]   m_sequence_number,
    output logic [h264fu_pkg::TS_W-1:0]    m_frame_timestamp,
    output logic                           m_last_of_run
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    h264fu_pkg::entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    h264fu_pkg::beat_t beat_reg, beat_next;

    h264fu_pkg::entry_t head;
    logic push, pop, beat_last, is_data;

    assign head     = mem[rd_ptr_reg];
    assign in_ready = (count_reg < CNT_W'(DEPTH));
    assign m_valid  = (count_reg != '0);
    assign push     = in_valid && in_ready;

    always_comb begin
        is_data   = !head.has_hdr || (beat_reg == h264fu_pkg::BEAT_DATA);
        beat_last = is_data;
        pop       = m_valid && m_ready && beat_last;
        beat_next = beat_reg;

        m_payload_byte    = head.data;
        m_packet_start    = head.pkt_start;
        m_packet_end      = head.pkt_end;
        m_sequence_number = head.seq;
        m_frame_timestamp = head.ts;
        m_last_of_run     = beat_last;

        if (!is_data) begin
            m_packet_end = 1'b0;
            if (beat_reg == h264fu_pkg::BEAT_FIRST) begin
                m_payload_byte = head.fu_ind;
                m_packet_start = 1'b1;
            end else begin
                m_payload_byte = head.fu_hdr;
                m_packet_start = 1'b0;
            end
        end

        if (m_valid && m_ready) begin
            case (beat_reg)
                h264fu_pkg::BEAT_FIRST: beat_next = is_data ? h264fu_pkg::BEAT_FIRST
                                                            : h264fu_pkg::BEAT_FUH;
                h264fu_pkg::BEAT_FUH:   beat_next = h264fu_pkg::BEAT_DATA;
                h264fu_pkg::BEAT_DATA:  beat_next = h264fu_pkg::BEAT_FIRST;
                default:                beat_next = h264fu_pkg::BEAT_FIRST;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg <= h264fu_pkg::BEAT_FIRST;
        end else begin
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_entry;
        end
    end

    `H264FU_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `H264FU_ASSERT_SAME(a_beat_idle, aclk, aresetn, !m_valid, beat_reg == h264fu_pkg::BEAT_FIRST)
    `H264FU_ASSERT_SAME(a_plain_beat, aclk, aresetn, m_valid && !head.has_hdr, beat_reg == h264fu_pkg::BEAT_FIRST)
    `H264FU_ASSERT_NEXT(a_pop_rewinds, aclk, aresetn, pop, beat_reg == h264fu_pkg::BEAT_FIRST)

endmodule

@@ rtl/h264_rtp_fu_a_packetizer.sv @@
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    nal_byte, nal_length, frame_end
// m_        out        m_valid / m_ready    payload_byte, packet_start, packet_end,
//                                           sequence_number, frame_timestamp, last_of_run
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One NAL byte is accepted per cycle while s_ready is high; its results go through the
// output queue to m_. A byte that opens an FU-A chunk yields three results; the single
// output beat per cycle, while m_ready is high, sets the sustained rate.
// A queue of QUEUE_DEPTH entries absorbs output stalls; s_ready drops when it is full.
// aresetn is synchronous, active low; it clears all counters and loads register defaults.
// cfg_ready is always high.
module h264_rtp_fu_a_packetizer #(
    parameter int LENGTH_BITS = h264fu_pkg::LENGTH_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = h264fu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_nal_byte,
    input  logic [h264fu_pkg::NAL_LENGTH_W-1:0]  s_nal_length,
    input  logic                                 s_frame_end,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [7:0]                           m_payload_byte,
    output logic                                 m_packet_start,
    output logic                                 m_packet_end,
    output logic [h264fu_pkg::SEQ_W-1:0]         m_sequence_number,
    output logic [h264fu_pkg::TS_W-1:0]          m_frame_timestamp,
    output logic                                 m_last_of_run,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [h264fu_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [h264fu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int LB = LENGTH_BITS;
    localparam int CW = LENGTH_BITS + h264fu_pkg::MP_W;
    localparam int MP_W = h264fu_pkg::MP_W;

    logic [MP_W-1:0]                  max_payload_reg;
    logic [h264fu_pkg::TS_STEP_W-1:0] ts_step_reg;

    logic [LB-1:0]                byte_pos_reg, byte_pos_next;
    logic [LB-1:0]                unit_len_reg, unit_len_next;
    logic [7:0]                   saved_hdr_reg, saved_hdr_next;
    logic                         frag_reg, frag_next;
    logic [MP_W-1:0]              chunk_off_reg, chunk_off_next;
    logic [h264fu_pkg::SEQ_W-1:0] seq_reg, seq_next;
    logic [h264fu_pkg::TS_W-1:0]  ts_reg, ts_next;

    logic [LB-1:0]   len_raw, len_in, remaining;
    logic [MP_W-1:0] mp_eff;
    logic [LB:0]     pos_inc;
    logic [MP_W:0]   off_inc;
    logic            first, last_byte, eop, push, accept, q_ready;
    h264fu_pkg::entry_t entry;

    assign cfg_ready = 1'b1;
    assign s_ready   = q_ready;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= h264fu_pkg::MAX_PAYLOAD_RESET;
            ts_step_reg     <= h264fu_pkg::TS_STEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                h264fu_pkg::REG_MAX_PAYLOAD:    max_payload_reg <= cfg_data[MP_W-1:0];
                h264fu_pkg::REG_TIMESTAMP_STEP: ts_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        len_raw = LB'(s_nal_length);
        len_in  = (len_raw == '0) ? LB'(1) : len_raw;
        mp_eff  = (max_payload_reg == '0) ? MP_W'(1) : max_payload_reg;
        first   = (byte_pos_reg == '0);

        unit_len_next  = first ? len_in : unit_len_reg;
        saved_hdr_next = first ? s_nal_byte : saved_hdr_reg;
        frag_next      = first ? (CW'(len_in) > CW'(mp_eff)) : frag_reg;
        chunk_off_next = first ? '0 : chunk_off_reg;

        pos_inc   = {1'b0, byte_pos_reg} + 1'b1;
        last_byte = (pos_inc == {1'b0, unit_len_next});
        remaining = unit_len_next - byte_pos_reg;
        off_inc   = {1'b0, chunk_off_next} + 1'b1;

        push          = 1'b0;
        eop           = 1'b0;
        entry.fu_ind  = (saved_hdr_next & h264fu_pkg::NRI_MASK) | h264fu_pkg::FU_A_TYPE;
        entry.fu_hdr  = saved_hdr_next & h264fu_pkg::TYPE_MASK;
        entry.data    = s_nal_byte;
        entry.has_hdr = 1'b0;
        entry.pkt_start = first;
        entry.pkt_end   = last_byte;
        entry.seq       = seq_reg;
        entry.ts        = ts_reg;

        if (!frag_next) begin
            push = 1'b1;
            eop  = last_byte;
        end else if (!first) begin
            // fragmented unit: a chunk's first byte also carries FU indicator and FU header
            push            = 1'b1;
            entry.has_hdr   = (chunk_off_next == '0);
            entry.pkt_start = 1'b0;
            if (byte_pos_reg == LB'(1)) begin
                entry.fu_hdr = entry.fu_hdr | h264fu_pkg::FU_START;
            end
            if (CW'(remaining) <= CW'(mp_eff)) begin
                entry.fu_hdr = entry.fu_hdr | h264fu_pkg::FU_END;
            end
            eop           = last_byte || (off_inc == {1'b0, mp_eff});
            entry.pkt_end = eop;
            chunk_off_next = eop ? '0 : off_inc[MP_W-1:0];
        end

        seq_next      = eop ? seq_reg + 1'b1 : seq_reg;
        ts_next       = ts_reg;
        byte_pos_next = pos_inc[LB-1:0];
        if (last_byte) begin
            byte_pos_next  = '0;
            frag_next      = 1'b0;
            chunk_off_next = '0;
            if (s_frame_end) begin
                ts_next = ts_reg + h264fu_pkg::TS_W'(ts_step_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg  <= '0;
            unit_len_reg  <= '0;
            saved_hdr_reg <= '0;
            frag_reg      <= 1'b0;
            chunk_off_reg <= '0;
            seq_reg       <= '0;
            ts_reg        <= '0;
        end else if (accept) begin
            byte_pos_reg  <= byte_pos_next;
            unit_len_reg  <= unit_len_next;
            saved_hdr_reg <= saved_hdr_next;
            frag_reg      <= frag_next;
            chunk_off_reg <= chunk_off_next;
            seq_reg       <= seq_next;
            ts_reg        <= ts_next;
        end
    end

    h264fu_out_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_out_queue (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (accept && push),
        .in_entry          (entry),
        .in_ready          (q_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_payload_byte    (m_payload_byte),
        .m_packet_start    (m_packet_start),
        .m_packet_end      (m_packet_end),
        .m_sequence_number (m_sequence_number),
        .m_frame_timestamp (m_frame_timestamp),
        .m_last_of_run     (m_last_of_run)
    );

endmodule

@@ tb/h264_rtp_fu_a_packetizer_checker.sv @@
`timescale 1ns / 1ps

module h264_rtp_fu_a_packetizer_checker
    import h264fu_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [7:0]              s_nal_byte,
    input  logic [NAL_LENGTH_W-1:0] s_nal_length,
    input  logic                    s_frame_end,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [7:0]              m_payload_byte,
    input  logic                    m_packet_start,
    input  logic                    m_packet_end,
    input  logic [SEQ_W-1:0]        m_sequence_number,
    input  logic [TS_W-1:0]         m_frame_timestamp,
    input  logic                    m_last_of_run,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      miscompare_count,
    output int                      beats_pending
);

    typedef struct packed {
        logic [7:0]       payload;
        logic             pkt_start;
        logic             pkt_end;
        logic [SEQ_W-1:0] seq;
        logic [TS_W-1:0]  ts;
        logic             last;
    } payload_beat_t;

    payload_beat_t          pending_beats[$];

    logic [MP_W-1:0]        max_payload = MAX_PAYLOAD_RESET;
    logic [TS_STEP_W-1:0]   ts_step = TS_STEP_RESET;
    logic [15:0]            byte_pos = '0;
    logic [15:0]            unit_len = '0;
    logic [7:0]             nal_header = '0;
    logic                   in_fu = 1'b0;
    logic [MP_W-1:0]        chunk_pos = '0;
    logic [SEQ_W-1:0]       seq_count = '0;
    logic [TS_W-1:0]        ts_count = '0;

    function automatic payload_beat_t make_beat(input logic [7:0] value, input logic first,
                                                input logic closing);
        payload_beat_t beat;
        beat.payload   = value;
        beat.pkt_start = first;
        beat.pkt_end   = closing;
        beat.seq       = seq_count;
        beat.ts        = ts_count;
        beat.last      = 1'b0;
        return beat;
    endfunction

    function automatic string beat_text(input payload_beat_t beat);
        return $sformatf("byte %02h start %0b end %0b seq %0d ts %0d last %0b",
                         beat.payload, beat.pkt_start, beat.pkt_end, beat.seq, beat.ts,
                         beat.last);
    endfunction

    task automatic flag_error(input string msg);
        miscompare_count++;
        if (miscompare_count <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // Work out the payload bytes that one accepted NAL byte produces.
    task automatic packetize_byte(input logic [7:0] value, input logic [15:0] len_in,
                                  input logic fe);
        logic [MP_W-1:0] mp_eff;
        logic            pkt_done;
        logic [7:0]      fu_header;
        payload_beat_t   beats[$];
        mp_eff   = (max_payload == '0) ? MP_W'(1) : max_payload;
        pkt_done = 1'b0;
        if (byte_pos == 16'd0) begin
            unit_len   = (len_in == 16'd0) ? 16'd1 : len_in;
            nal_header = value;
            in_fu      = (unit_len > mp_eff);
            chunk_pos  = '0;
        end
        if (!in_fu) begin
            pkt_done = (byte_pos + 1 == unit_len);
            beats.push_back(make_beat(value, byte_pos == 16'd0, pkt_done));
        end else if (byte_pos != 16'd0) begin
            if (chunk_pos == '0) begin
                fu_header = nal_header & TYPE_MASK;
                if (byte_pos == 16'd1) begin
                    fu_header = fu_header | FU_START;
                end
                if (unit_len - byte_pos <= mp_eff) begin
                    fu_header = fu_header | FU_END;
                end
                beats.push_back(make_beat((nal_header & NRI_MASK) | FU_A_TYPE, 1'b1, 1'b0));
                beats.push_back(make_beat(fu_header, 1'b0, 1'b0));
            end
            pkt_done = (byte_pos + 1 == unit_len) || (chunk_pos + 1 == mp_eff);
            beats.push_back(make_beat(value, 1'b0, pkt_done));
            chunk_pos = pkt_done ? '0 : chunk_pos + 1'b1;
        end
        if (beats.size() > 0) begin
            beats[beats.size() - 1].last = 1'b1;
            foreach (beats[i]) begin
                pending_beats.push_back(beats[i]);
            end
        end
        if (pkt_done) begin
            seq_count = seq_count + 1'b1;
        end
        byte_pos = byte_pos + 1'b1;
        if (byte_pos >= unit_len) begin
            byte_pos  = '0;
            in_fu     = 1'b0;
            chunk_pos = '0;
            // timestamp moves only after the closing byte of the frame
            if (fe) begin
                ts_count = ts_count + ts_step;
            end
        end
    endtask

    always @(posedge aclk) begin : monitor
        payload_beat_t seen;
        payload_beat_t want;
        if (!aresetn) begin
            max_payload = MAX_PAYLOAD_RESET;
            ts_step     = TS_STEP_RESET;
            byte_pos    = '0;
            unit_len    = '0;
            nal_header  = '0;
            in_fu       = 1'b0;
            chunk_pos   = '0;
            seq_count   = '0;
            ts_count    = '0;
            pending_beats.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAX_PAYLOAD: begin
                        max_payload = cfg_data[MP_W-1:0];
                    end
                    REG_TIMESTAMP_STEP: begin
                        ts_step = cfg_data[TS_STEP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // compare before predicting: a result never belongs to a same-edge transaction
            if (m_valid && m_ready) begin
                seen.payload   = m_payload_byte;
                seen.pkt_start = m_packet_start;
                seen.pkt_end   = m_packet_end;
                seen.seq       = m_sequence_number;
                seen.ts        = m_frame_timestamp;
                seen.last      = m_last_of_run;
                if (pending_beats.size() == 0) begin
                    flag_error({"unexpected result: ", beat_text(seen)});
                end else begin
                    want = pending_beats.pop_front();
                    if (seen.payload != want.payload || seen.pkt_start != want.pkt_start ||
                        seen.pkt_end != want.pkt_end || seen.seq != want.seq ||
                        seen.ts != want.ts || seen.last != want.last) begin
                        flag_error({"miscompare: expected ", beat_text(want),
                                    " got ", beat_text(seen)});
                    end
                end
            end
            if (s_valid && s_ready) begin
                packetize_byte(s_nal_byte, s_nal_length, s_frame_end);
            end
        end
        beats_pending = pending_beats.size();
    end

endmodule

@@ tb/h264_rtp_fu_a_packetizer_tb.sv @@
`timescale 1ns / 1ps

module h264_rtp_fu_a_packetizer_tb;
    import h264fu_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_BYTES = 80;
    localparam int IDLE_PCT[4]  = '{0, 46, 0, 20};
    localparam int STALL_PCT[4] = '{0, 0, 46, 20};

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_nal_byte = '0;
    logic [NAL_LENGTH_W-1:0] s_nal_length = '0;
    logic                    s_frame_end = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [7:0]              m_payload_byte;
    logic                    m_packet_start;
    logic                    m_packet_end;
    logic [SEQ_W-1:0]        m_sequence_number;
    logic [TS_W-1:0]         m_frame_timestamp;
    logic                    m_last_of_run;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = REG_MAX_PAYLOAD;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    int miscompare_count;
    int beats_pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    int cur_mp = MAX_PAYLOAD_RESET;
    int sent_bytes = 0;

    h264_rtp_fu_a_packetizer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_nal_byte        (s_nal_byte),
        .s_nal_length      (s_nal_length),
        .s_frame_end       (s_frame_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_payload_byte    (m_payload_byte),
        .m_packet_start    (m_packet_start),
        .m_packet_end      (m_packet_end),
        .m_sequence_number (m_sequence_number),
        .m_frame_timestamp (m_frame_timestamp),
        .m_last_of_run     (m_last_of_run),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    h264_rtp_fu_a_packetizer_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_nal_byte        (s_nal_byte),
        .s_nal_length      (s_nal_length),
        .s_frame_end       (s_frame_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_payload_byte    (m_payload_byte),
        .m_packet_start    (m_packet_start),
        .m_packet_end      (m_packet_end),
        .m_sequence_number (m_sequence_number),
        .m_frame_timestamp (m_frame_timestamp),
        .m_last_of_run     (m_last_of_run),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .miscompare_count  (miscompare_count),
        .beats_pending     (beats_pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one NAL byte and hold it until the transaction completes.
    task automatic send_byte(input logic [7:0] value, input logic [15:0] len, input logic fe);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_nal_byte   <= value;
        s_nal_length <= len;
        s_frame_end  <= fe;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_bytes++;
        @(negedge aclk);
    endtask

    // Send bytes first..stop-1 of a unit; stop of zero runs to the unit's end.
    // Length and frame_end carry noise on the bytes where the block ignores them.
    task automatic send_nal(input logic [7:0] hdr, input logic [15:0] len_field,
                            input logic fe, input int first, input int stop);
        int unit_bytes;
        unit_bytes = (len_field == 16'd0) ? 1 : int'(len_field);
        if (stop == 0) begin
            stop = unit_bytes;
        end
        for (int k = first; k < stop; k++) begin
            send_byte((k == 0) ? hdr : 8'($urandom),
                      (k == 0) ? len_field : 16'($urandom),
                      (k == unit_bytes - 1) ? fe : 1'($urandom));
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (beats_pending != 0) @(negedge aclk);
        // a header byte of a fragmented unit may still be in flight with nothing expected
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_MAX_PAYLOAD) begin
            cur_mp = value;
        end
    endtask

    initial begin : stimulus
        int len_field;
        int pick;
        int mp_eff;
        int phase_start;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_reg(REG_MAX_PAYLOAD, 4);
        write_reg(REG_TIMESTAMP_STEP, 90000);
        send_nal(8'h00, 16'd0, 1'b1, 0, 0);     // zero length becomes one byte
        send_nal(8'hFF, 16'd1, 1'b0, 0, 0);
        send_nal(8'h65, 16'd4, 1'b1, 0, 0);     // fits exactly, no fragmentation
        send_nal(8'h7F, 16'd5, 1'b0, 0, 0);     // one FU with start and end bits
        send_nal(8'hE5, 16'd10, 1'b1, 0, 0);    // full, full, short chunk
        // change max_payload in the middle of a fragmented unit, to zero
        send_nal(8'h41, 16'd6, 1'b1, 0, 3);
        write_reg(REG_MAX_PAYLOAD, 0);
        send_nal(8'h41, 16'd6, 1'b1, 3, 0);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    write_reg(REG_MAX_PAYLOAD, 3);
                    write_reg(REG_TIMESTAMP_STEP, 0);
                end
                1: begin
                    write_reg(REG_MAX_PAYLOAD, $urandom_range(1, 12));
                    write_reg(REG_TIMESTAMP_STEP, $urandom_range(0, 90000));
                end
                2: begin
                    write_reg(REG_MAX_PAYLOAD, 4095);
                    write_reg(REG_TIMESTAMP_STEP, 90000);
                end
                default: begin
                    write_reg(REG_MAX_PAYLOAD, $urandom_range(2, 24));
                    write_reg(REG_TIMESTAMP_STEP, $urandom_range(1, 90000));
                end
            endcase
            idle_pct  = IDLE_PCT[p];
            stall_pct = STALL_PCT[p];
            phase_start = sent_bytes;
            while (sent_bytes - phase_start < PHASE_BYTES) begin
                pick   = $urandom_range(0, 99);
                mp_eff = (cur_mp == 0) ? 1 : cur_mp;
                if (pick < 6) begin
                    len_field = 0;
                end else if (pick < 12) begin
                    len_field = 1;
                end else if (pick < 70 && mp_eff < 64) begin
                    len_field = $urandom_range(mp_eff + 1, 3 * mp_eff + 2);
                end else begin
                    len_field = $urandom_range(2, (mp_eff < 40) ? mp_eff : 40);
                end
                if ($urandom_range(0, 9) == 0) begin
                    wait_drained();
                end
                send_nal(8'($urandom), 16'(len_field), 1'($urandom), 0, 0);
            end
        end

        // unit cut into one-byte chunks
        write_reg(REG_MAX_PAYLOAD, 1);
        idle_pct  = 0;
        stall_pct = 0;
        send_nal(8'($urandom), 16'd12, 1'b1, 0, 0);

        wait_drained();
        repeat (20) @(negedge aclk);
        if (miscompare_count == 0 && beats_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
